// ----- rtl/core/tensor_monomial_basis_generator_macros.svh -----
// assertion macros for the monomial basis generator
`ifndef TENSOR_MONOMIAL_BASIS_GENERATOR_MACROS_SVH
`define TENSOR_MONOMIAL_BASIS_GENERATOR_MACROS_SVH

// same-cycle implication
`define TMBG_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tmbg: same-cycle check failed");

// next-cycle implication
`define TMBG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tmbg: next-cycle check failed");

`endif

// ----- rtl/core/tmbg_pkg.sv -----
// shared types and constants of the monomial basis generator
package tmbg_pkg;

   localparam int NUM_AXES    = 3;
   localparam int COORD_W     = 16;
   localparam int COORD_SHIFT = 14;
   localparam int Q_FRAC      = 28;
   localparam int ENTRY_W     = 33;
   localparam int MAG_W       = 32;
   localparam int AB_W        = 35;
   localparam int HALF_W      = 16;
   localparam int MONO_W      = 39;
   localparam int VALUE_W     = 48;
   localparam int IDX_W       = 6;
   localparam int NV_W        = 2;
   localparam int DEG_W       = 2;
   localparam int VAR_W       = 2;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 2;

   localparam logic signed [ENTRY_W-1:0] ONE_Q = ENTRY_W'(1) << Q_FRAC;
   localparam logic [MAG_W-1:0]          MAG_ONE = MAG_W'(1) << Q_FRAC;

   localparam logic CMD_PLAIN = 1'b0;
   localparam logic CMD_DERIV = 1'b1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_NUM_VARS      = 2'd0,
      CSR_DEGREE_FIRST  = 2'd1,
      CSR_DEGREE_SECOND = 2'd2,
      CSR_DEGREE_THIRD  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PW_IDLE,
      PW_BUILD,
      PW_LAUNCH
   } pw_state_type;

   typedef struct packed {
      logic                      cmd;
      logic [VAR_W-1:0]          diff_var;
      logic signed [COORD_W-1:0] coord_a;
      logic signed [COORD_W-1:0] coord_b;
      logic signed [COORD_W-1:0] coord_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          basis_index;
      logic signed [VALUE_W-1:0] basis_value;
      logic                      last_item;
      logic                      bad_variable;
   } rsp_type;

   typedef struct packed {
      logic                               bad;
      logic [NV_W-1:0]                    nv;
      logic [NUM_AXES-1:0][DEG_W-1:0]     deg;
   } job_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic             bad;
      logic [NV_W-1:0]  nv;
   } side_type;

endpackage

// ----- rtl/core/tensor_monomial_basis_generator.sv -----
// Tensor-product monomial basis generator. A request carries up to three
// signed Q1.14 coordinates; the block answers with the Kronecker product of
// the per-variable power vectors [1, x, ..., x^d] (or, with cmd set, the
// derivative vector of diff_var), one Q19.28 result per cycle while the
// output is not stalled, in Kronecker order with the last one marked. An
// invalid diff_var gives one flagged zero result. Per request: the request
// is taken, the sum(d_v + 1) power-table entries are built through the
// shared coordinate multiplier (none for an invalid diff_var), a launch
// state follows, then prod(d_v + 1) results are issued from the table
// memories into a five-stage product pipeline; the next request is taken
// as soon as the last result has been issued.
// Configuration is written through csr_wr_en / csr_addr / csr_wr_data.
`include "tensor_monomial_basis_generator_macros.svh"

module tensor_monomial_basis_generator import tmbg_pkg::*; #(
   parameter int MAX_VARS   = 3,
   parameter int MAX_DEGREE = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wr_data
);

   localparam int ADDR_W    = $clog2(MAX_DEGREE + 1);
   localparam int RAM_DEPTH = MAX_DEGREE + 1;

   logic [NV_W-1:0]                num_vars_ff;
   logic [NUM_AXES-1:0][DEG_W-1:0] deg_ff;

   logic                             seq_busy;
   logic                             job_start;
   job_type                          job;
   logic [MAX_VARS-1:0]              ram_wr_en;
   logic [ADDR_W-1:0]                ram_wr_addr;
   logic signed [ENTRY_W-1:0]        ram_wr_data;
   logic [NUM_AXES-1:0][ADDR_W-1:0]  ram_rd_addr;
   logic [NUM_AXES-1:0][ENTRY_W-1:0] ram_rd_data;
   logic                             adv;
   logic                             iss_valid;
   side_type                         iss_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff <= NV_W'(1);
         deg_ff      <= {NUM_AXES{DEG_W'(1)}};
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_NUM_VARS:      num_vars_ff <= csr_wr_data;
            CSR_DEGREE_FIRST:  deg_ff[0]   <= csr_wr_data;
            CSR_DEGREE_SECOND: deg_ff[1]   <= csr_wr_data;
            CSR_DEGREE_THIRD:  deg_ff[2]   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   tmbg_power #(
      .MAX_VARS   (MAX_VARS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_power (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .cfg_num_vars (num_vars_ff),
      .cfg_deg      (deg_ff),
      .seq_busy     (seq_busy),
      .job_start    (job_start),
      .job          (job),
      .wr_en        (ram_wr_en),
      .wr_addr      (ram_wr_addr),
      .wr_data      (ram_wr_data)
   );

   // one power-table memory per variable
   for (genvar v = 0; v < NUM_AXES; v++) begin : g_table
      if (v < MAX_VARS) begin : g_ram
         tmbg_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (RAM_DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (ram_wr_en[v]),
            .wr_addr (ram_wr_addr),
            .wr_data (ram_wr_data),
            .rd_en   (adv),
            .rd_addr (ram_rd_addr[v]),
            .rd_data (ram_rd_data[v])
         );
      end else begin : g_none
         assign ram_rd_data[v] = '0;
      end
   end

   tmbg_seq #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .job_start (job_start),
      .job       (job),
      .busy      (seq_busy),
      .rd_addr   (ram_rd_addr),
      .iss_valid (iss_valid),
      .iss_side  (iss_side)
   );

   tmbg_mono_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .iss_valid (iss_valid),
      .iss_side  (iss_side),
      .rd_data   (ram_rd_data),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `TMBG_ASSERT_IMPLY(a_bad_single, clock, reset, rsp_valid && rsp_data.bad_variable, rsp_data.last_item && rsp_data.basis_index == '0 && rsp_data.basis_value == '0)
   `TMBG_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_item, !rsp_valid || rsp_data.basis_index == IDX_W'($past(rsp_data.basis_index) + 1'b1))
   `TMBG_ASSERT_IMPLY(a_table_quiet, clock, reset, |ram_wr_en, !seq_busy)
   `TMBG_ASSERT_IMPLY(a_launch_idle, clock, reset, job_start, !seq_busy)

endmodule

// ----- rtl/core/tmbg_ram.sv -----
// generic single-port-write ram with registered read
module tmbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tmbg_power.sv -----
// power vector builder: one table entry per cycle through a shared multiplier
module tmbg_power import tmbg_pkg::*; #(
   parameter int MAX_VARS   = 3,
   parameter int MAX_DEGREE = 3,
   localparam int ADDR_W = $clog2(MAX_DEGREE + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  req_type                          req_data,
   input  logic [NV_W-1:0]                  cfg_num_vars,
   input  logic [NUM_AXES-1:0][DEG_W-1:0]   cfg_deg,
   input  logic                             seq_busy,
   output logic                             job_start,
   output job_type                          job,
   output logic [MAX_VARS-1:0]              wr_en,
   output logic [ADDR_W-1:0]                wr_addr,
   output logic signed [ENTRY_W-1:0]        wr_data
);

   localparam int PROD_W = MAG_W + COORD_W;
   localparam logic [PROD_W-1:0] STEP_HALF = PROD_W'(1) << (COORD_SHIFT - 1);

   pw_state_type state_ff, state_in;

   job_type                   job_ff;
   logic                      cmd_ff;
   logic [VAR_W-1:0]          dvar_ff;
   logic signed [COORD_W-1:0] coord_ff [NUM_AXES];
   logic [VAR_W-1:0]          v_ff;
   logic [ADDR_W-1:0]         j_ff;
   logic signed [ENTRY_W-1:0] p_ff;

   logic                      accept;
   job_type                   job_new;
   logic [NV_W-1:0]           nv_clamp;
   logic [ADDR_W-1:0]         cur_deg;
   logic                      deriv;
   logic                      row_end;
   logic                      var_end;
   logic signed [COORD_W-1:0] x_cur;
   logic                      x_neg;
   logic [COORD_W-1:0]        x_mag;
   logic                      p_neg;
   logic [MAG_W-1:0]          p_mag;
   logic [PROD_W-1:0]         step_sum;
   logic signed [ENTRY_W-1:0] step_mag;
   logic signed [ENTRY_W-1:0] step_val;

   // snapshot of the configuration with out-of-range values clamped
   always_comb begin
      if (cfg_num_vars == '0) begin
         nv_clamp = NV_W'(1);
      end else if (int'(cfg_num_vars) > MAX_VARS) begin
         nv_clamp = NV_W'(MAX_VARS);
      end else begin
         nv_clamp = cfg_num_vars;
      end
      job_new.nv  = nv_clamp;
      job_new.bad = (req_data.cmd == CMD_DERIV) && (req_data.diff_var >= nv_clamp);
      for (int v = 0; v < NUM_AXES; v++) begin
         job_new.deg[v] = (int'(cfg_deg[v]) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg_deg[v];
      end
   end

   assign accept  = req_valid && req_ready;
   assign cur_deg = ADDR_W'(job_ff.deg[v_ff]);
   assign deriv   = (cmd_ff == CMD_DERIV) && (dvar_ff == v_ff);
   assign row_end = (j_ff == cur_deg);
   assign var_end = (v_ff == VAR_W'(job_ff.nv - NV_W'(1)));

   // next power: round half away from zero of p * x in q.28
   assign x_cur    = coord_ff[v_ff];
   assign x_neg    = x_cur[COORD_W-1];
   assign x_mag    = x_neg ? COORD_W'(-x_cur) : COORD_W'(x_cur);
   assign p_neg    = p_ff[ENTRY_W-1];
   assign p_mag    = p_neg ? MAG_W'(-p_ff) : MAG_W'(p_ff);
   assign step_sum = (PROD_W'(p_mag) * PROD_W'(x_mag)) + STEP_HALF;
   assign step_mag = signed'(ENTRY_W'(step_sum >> COORD_SHIFT));
   assign step_val = (p_neg != x_neg) ? -step_mag : step_mag;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PW_IDLE: begin
            if (accept) begin
               state_in = job_new.bad ? PW_LAUNCH : PW_BUILD;
            end
         end
         PW_BUILD: begin
            if (row_end && var_end) begin
               state_in = PW_LAUNCH;
            end
         end
         PW_LAUNCH: state_in = PW_IDLE;
         default:   state_in = PW_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == PW_IDLE) && !seq_busy;
      job_start = (state_ff == PW_LAUNCH);
      for (int v = 0; v < MAX_VARS; v++) begin
         wr_en[v] = (state_ff == PW_BUILD) && (v_ff == VAR_W'(v));
      end
   end

   always_comb begin
      if (!deriv) begin
         wr_data = p_ff;
      end else if (j_ff == '0) begin
         wr_data = '0;
      end else begin
         wr_data = ENTRY_W'(p_ff * signed'({1'b0, j_ff}));
      end
   end

   assign wr_addr = j_ff;
   assign job     = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PW_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff      <= job_new;
         cmd_ff      <= req_data.cmd;
         dvar_ff     <= req_data.diff_var;
         coord_ff[0] <= req_data.coord_a;
         coord_ff[1] <= req_data.coord_b;
         coord_ff[2] <= req_data.coord_c;
         v_ff        <= '0;
         j_ff        <= '0;
         p_ff        <= ONE_Q;
      end else if (state_ff == PW_BUILD) begin
         if (row_end) begin
            v_ff <= v_ff + VAR_W'(1);
            j_ff <= '0;
            p_ff <= ONE_Q;
         end else begin
            j_ff <= j_ff + ADDR_W'(1);
            if (!(deriv && j_ff == '0)) begin
               p_ff <= step_val;
            end
         end
      end
   end

endmodule

// ----- rtl/core/tmbg_seq.sv -----
// kronecker-order sequencer: one table read per cycle while not stalled, last variable fastest
module tmbg_seq import tmbg_pkg::*; #(
   parameter int MAX_DEGREE = 3,
   localparam int ADDR_W = $clog2(MAX_DEGREE + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             job_start,
   input  job_type                          job,
   output logic                             busy,
   output logic [NUM_AXES-1:0][ADDR_W-1:0]  rd_addr,
   output logic                             iss_valid,
   output side_type                         iss_side
);

   logic                     busy_ff, busy_in;
   logic                     bad_ff;
   logic [NV_W-1:0]          nv_ff;
   logic [ADDR_W-1:0]        last_k_ff [NUM_AXES];
   logic [ADDR_W-1:0]        last_k_in [NUM_AXES];
   logic [ADDR_W-1:0]        cnt_ff [NUM_AXES];
   logic [ADDR_W-1:0]        cnt_in [NUM_AXES];
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     all_end;
   logic                     iss_last;

   always_comb begin
      all_end = 1'b1;
      for (int v = 0; v < NUM_AXES; v++) begin
         if (cnt_ff[v] != last_k_ff[v]) begin
            all_end = 1'b0;
         end
         last_k_in[v] = (NV_W'(v) < job.nv) ? ADDR_W'(job.deg[v]) : '0;
      end
   end

   assign iss_last = bad_ff || all_end;

   always_comb begin
      logic carry;
      carry   = 1'b1;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      for (int v = NUM_AXES - 1; v >= 0; v--) begin
         cnt_in[v] = cnt_ff[v];
      end
      if (job_start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         for (int v = 0; v < NUM_AXES; v++) begin
            cnt_in[v] = '0;
         end
      end else if (busy_ff && adv) begin
         if (iss_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
            for (int v = NUM_AXES - 1; v >= 0; v--) begin
               if (carry) begin
                  if (cnt_ff[v] == last_k_ff[v]) begin
                     cnt_in[v] = '0;
                  end else begin
                     cnt_in[v] = cnt_ff[v] + ADDR_W'(1);
                     carry     = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      for (int v = 0; v < NUM_AXES; v++) begin
         cnt_ff[v] <= cnt_in[v];
      end
      if (job_start) begin
         bad_ff <= job.bad;
         nv_ff  <= job.nv;
         for (int v = 0; v < NUM_AXES; v++) begin
            last_k_ff[v] <= last_k_in[v];
         end
      end
   end

   always_comb begin
      for (int v = 0; v < NUM_AXES; v++) begin
         rd_addr[v] = cnt_ff[v];
      end
   end

   assign busy          = busy_ff;
   assign iss_valid     = busy_ff;
   assign iss_side.idx  = idx_ff;
   assign iss_side.last = iss_last;
   assign iss_side.bad  = bad_ff;
   assign iss_side.nv   = nv_ff;

endmodule

// ----- rtl/core/tmbg_mono_pipe.sv -----
// monomial product pipeline: sign-magnitude multiply, round, split multiply, round
module tmbg_mono_pipe import tmbg_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             iss_valid,
   input  side_type                         iss_side,
   input  logic [NUM_AXES-1:0][ENTRY_W-1:0] rd_data,
   output logic                             adv,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsp_type                          rsp_data
);

   localparam int AB_PROD_W = 2 * MAG_W;
   localparam int PART_W    = AB_W + HALF_W;
   localparam int SUM_W     = AB_W + MAG_W;
   localparam logic [AB_PROD_W-1:0] AB_HALF  = AB_PROD_W'(1) << (Q_FRAC - 1);
   localparam logic [SUM_W-1:0]     SUM_HALF = SUM_W'(1) << (Q_FRAC - 1);

   // stage 1: aligned with the registered table reads
   logic     valid1_ff;
   side_type side1_ff;
   // stage 2
   logic                 valid2_ff;
   side_type             side2_ff;
   logic [AB_PROD_W-1:0] prod2_ff;
   logic [MAG_W-1:0]     c_mag2_ff;
   logic                 neg2_ff;
   // stage 3
   logic             valid3_ff;
   side_type         side3_ff;
   logic [AB_W-1:0]  ab3_ff;
   logic [MAG_W-1:0] c_mag3_ff;
   logic             neg3_ff;
   // stage 4
   logic              valid4_ff;
   side_type          side4_ff;
   logic [PART_W-1:0] plo4_ff;
   logic [PART_W-1:0] phi4_ff;
   logic              neg4_ff;
   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic signed [ENTRY_W-1:0] lane_val [NUM_AXES];
   logic                      lane_neg [NUM_AXES];
   logic [MAG_W-1:0]          lane_mag [NUM_AXES];
   logic                      use_b;
   logic                      use_c;
   logic [MAG_W-1:0]          b_mag;
   logic [MAG_W-1:0]          c_mag;
   logic                      neg1;
   logic [AB_PROD_W-1:0]      ab_prod;
   logic [AB_PROD_W-1:0]      ab_sum;
   logic [AB_W-1:0]           ab_mag;
   logic [PART_W-1:0]         plo;
   logic [PART_W-1:0]         phi;
   logic [SUM_W-1:0]          mono_sum;
   logic [MONO_W-1:0]         mono_mag;
   logic signed [VALUE_W-1:0] mono_ext;
   rsp_type                   rsp_in;

   assign adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int v = 0; v < NUM_AXES; v++) begin
         lane_val[v] = signed'(rd_data[v]);
         lane_neg[v] = lane_val[v][ENTRY_W-1];
         lane_mag[v] = lane_neg[v] ? MAG_W'(-lane_val[v]) : MAG_W'(lane_val[v]);
      end
   end

   // an unused variable multiplies by one, which rounds back exactly
   assign use_b   = (side1_ff.nv >= NV_W'(2));
   assign use_c   = (side1_ff.nv >= NV_W'(3));
   assign b_mag   = use_b ? lane_mag[1] : MAG_ONE;
   assign c_mag   = use_c ? lane_mag[2] : MAG_ONE;
   assign neg1    = lane_neg[0] ^ (use_b & lane_neg[1]) ^ (use_c & lane_neg[2]);
   assign ab_prod = AB_PROD_W'(lane_mag[0]) * AB_PROD_W'(b_mag);

   assign ab_sum = prod2_ff + AB_HALF;
   assign ab_mag = AB_W'(ab_sum >> Q_FRAC);

   assign plo = PART_W'(ab3_ff) * PART_W'(c_mag3_ff[HALF_W-1:0]);
   assign phi = PART_W'(ab3_ff) * PART_W'(c_mag3_ff[MAG_W-1:HALF_W]);

   assign mono_sum = (SUM_W'(phi4_ff) << HALF_W) + SUM_W'(plo4_ff) + SUM_HALF;
   assign mono_mag = MONO_W'(mono_sum >> Q_FRAC);
   assign mono_ext = signed'(VALUE_W'(mono_mag));

   always_comb begin
      rsp_in.basis_index  = side4_ff.idx;
      rsp_in.last_item    = side4_ff.last;
      rsp_in.bad_variable = side4_ff.bad;
      if (side4_ff.bad) begin
         rsp_in.basis_value = '0;
      end else begin
         rsp_in.basis_value = neg4_ff ? -mono_ext : mono_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff    <= iss_valid;
         valid2_ff    <= valid1_ff;
         valid3_ff    <= valid2_ff;
         valid4_ff    <= valid3_ff;
         rsp_valid_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff    <= iss_side;
         side2_ff    <= side1_ff;
         prod2_ff    <= ab_prod;
         c_mag2_ff   <= c_mag;
         neg2_ff     <= neg1;
         side3_ff    <= side2_ff;
         ab3_ff      <= ab_mag;
         c_mag3_ff   <= c_mag2_ff;
         neg3_ff     <= neg2_ff;
         side4_ff    <= side3_ff;
         plo4_ff     <= plo;
         phi4_ff     <= phi;
         neg4_ff     <= neg3_ff;
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/tensor_monomial_basis_generator_tb.sv -----
// self-checking testbench for the tensor monomial basis generator
`timescale 1ns / 100ps

module tensor_monomial_basis_generator_tb;
   import tmbg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 100;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [CSR_AW-1:0]   csr_addr    = CSR_NUM_VARS;
   logic [CSR_DW-1:0]   csr_wr_data = '0;

   req_type             pending_points_q [$];
   rsp_type             expected_basis_q [$];

   logic [NV_W-1:0]     cfg_num_vars = 2'd1;
   logic [DEG_W-1:0]    cfg_degree [3] = '{2'd1, 2'd1, 2'd1};

   int                  idle_pct     = 35;
   int                  stall_pct    = 35;
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   tensor_monomial_basis_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // q.28 product, rounded half away from zero, saturated to 48 bits
   function automatic longint signed q28_mul(longint signed a, longint signed b);
      logic [127:0] ma, mb, q;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      q = (ma * mb + (128'd1 << (Q_FRAC - 1))) >> Q_FRAC;
      if (neg) begin
         if (q >= (128'd1 << 47))
            return -(64'sd1 <<< 47);
         return -$signed(q[63:0]);
      end
      if (q >= (128'd1 << 47))
         return (64'sd1 <<< 47) - 1;
      return $signed(q[63:0]);
   endfunction

   function automatic void predict_basis(req_type pt);
      longint signed pw [3][4];
      longint signed xq [3];
      longint signed p, val;
      int            nv, deg, total;
      int            len [3];
      rsp_type       r;
      nv = (cfg_num_vars == 0) ? 1 : int'(cfg_num_vars);
      r = '0;
      if (pt.cmd == CMD_DERIV && int'(pt.diff_var) >= nv) begin
         r.last_item = 1'b1;
         r.bad_variable = 1'b1;
         expected_basis_q = {expected_basis_q, r};
         return;
      end
      xq[0] = longint'($signed(pt.coord_a)) * 16384;
      xq[1] = longint'($signed(pt.coord_b)) * 16384;
      xq[2] = longint'($signed(pt.coord_c)) * 16384;
      for (int v = 0; v < 3; v++) begin
         len[v] = 1;
         for (int j = 0; j < 4; j++)
            pw[v][j] = 0;
         if (v < nv) begin
            deg = int'(cfg_degree[v]);
            len[v] = deg + 1;
            p = 64'sd1 <<< Q_FRAC;
            if (pt.cmd == CMD_DERIV && int'(pt.diff_var) == v) begin
               pw[v][0] = 0;
               for (int j = 1; j <= deg; j++) begin
                  pw[v][j] = p * j;
                  p = q28_mul(p, xq[v]);
               end
            end else begin
               for (int j = 0; j <= deg; j++) begin
                  pw[v][j] = p;
                  p = q28_mul(p, xq[v]);
               end
            end
         end
      end
      total = len[0] * len[1] * len[2];
      for (int k = 0; k < total; k++) begin
         val = pw[0][k / (len[2] * len[1])];
         if (nv > 1)
            val = q28_mul(val, pw[1][(k / len[2]) % len[1]]);
         if (nv > 2)
            val = q28_mul(val, pw[2][k % len[2]]);
         r.basis_index = 6'(k);
         r.basis_value = val[VALUE_W-1:0];
         r.last_item = (k == total - 1);
         r.bad_variable = 1'b0;
         expected_basis_q = {expected_basis_q, r};
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_basis(req_data);
         if (!req_valid || req_ready) begin
            if (pending_points_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_data <= pending_points_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_basis_q.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_data.basis_index), 64'd0);
            end else begin
               want = expected_basis_q.pop_front();
               if (rsp_data.basis_index !== want.basis_index)
                  report_mismatch("basis_index", 64'(rsp_data.basis_index),
                                  64'(want.basis_index));
               if (rsp_data.basis_value !== want.basis_value)
                  report_mismatch("basis_value", 64'(rsp_data.basis_value),
                                  64'(want.basis_value));
               if (rsp_data.last_item !== want.last_item)
                  report_mismatch("last_item", 64'(rsp_data.last_item), 64'(want.last_item));
               if (rsp_data.bad_variable !== want.bad_variable)
                  report_mismatch("bad_variable", 64'(rsp_data.bad_variable),
                                  64'(want.bad_variable));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tensor_monomial_basis_generator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_point(logic cmd, logic [VAR_W-1:0] dvar,
                              logic [COORD_W-1:0] a, b, c);
      req_type pt;
      pt.cmd = cmd;
      pt.diff_var = dvar;
      pt.coord_a = a;
      pt.coord_b = b;
      pt.coord_c = c;
      pending_points_q = {pending_points_q, pt};
   endtask

   // checked at the falling edge, where nothing is in motion
   task automatic wait_drained();
      @(negedge clock);
      while (pending_points_q.size() != 0 || req_valid || expected_basis_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_config(logic [1:0] nv, d0, d1, d2);
      csr_index_type regs [4];
      logic [1:0]    vals [4];
      regs = '{CSR_NUM_VARS, CSR_DEGREE_FIRST, CSR_DEGREE_SECOND, CSR_DEGREE_THIRD};
      vals = '{nv, d0, d1, d2};
      @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_addr <= regs[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
         case (regs[i])
            CSR_NUM_VARS:      cfg_num_vars = vals[i];
            CSR_DEGREE_FIRST:  cfg_degree[0] = vals[i];
            CSR_DEGREE_SECOND: cfg_degree[1] = vals[i];
            CSR_DEGREE_THIRD:  cfg_degree[2] = vals[i];
            default: ;
         endcase
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h4000;
         4: return 16'hc000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int         nv_eff;
      logic       cmd;
      logic [1:0] dvar;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: one variable of degree one
      queue_point(CMD_PLAIN, 2'd0, 16'h4000, 16'h0000, 16'h0000);
      queue_point(CMD_PLAIN, 2'd3, 16'h8000, 16'h7fff, 16'h8000);
      queue_point(CMD_DERIV, 2'd0, 16'h7fff, 16'h0000, 16'hffff);
      queue_point(CMD_DERIV, 2'd1, 16'h1234, 16'h8000, 16'h7fff);
      queue_point(CMD_DERIV, 2'd3, 16'hffff, 16'hffff, 16'hffff);
      wait_drained();

      write_config(2'd3, 2'd3, 2'd3, 2'd3);
      queue_point(CMD_PLAIN, 2'd0, 16'h8000, 16'h8000, 16'h8000);
      queue_point(CMD_PLAIN, 2'd2, 16'h7fff, 16'h7fff, 16'h7fff);
      queue_point(CMD_DERIV, 2'd0, 16'h8000, 16'h7fff, 16'hc000);
      queue_point(CMD_DERIV, 2'd1, 16'h7fff, 16'h8000, 16'h4000);
      queue_point(CMD_DERIV, 2'd2, 16'hc000, 16'h4000, 16'h8000);
      queue_point(CMD_DERIV, 2'd3, 16'h7fff, 16'h7fff, 16'h7fff);
      queue_point(CMD_PLAIN, 2'd1, 16'h0000, 16'h0000, 16'h0000);
      wait_drained();

      // zero variables read as one, zero-degree derivative
      write_config(2'd0, 2'd0, 2'd2, 2'd1);
      queue_point(CMD_DERIV, 2'd0, 16'h7fff, 16'h7fff, 16'h7fff);
      queue_point(CMD_DERIV, 2'd1, 16'h4000, 16'h4000, 16'h4000);
      queue_point(CMD_PLAIN, 2'd3, 16'h8000, 16'h0001, 16'h0001);
      wait_drained();

      write_config(2'd2, 2'd3, 2'd0, 2'd2);
      queue_point(CMD_DERIV, 2'd1, 16'h8000, 16'h8000, 16'h8000);
      queue_point(CMD_DERIV, 2'd0, 16'h8000, 16'h7fff, 16'h0000);
      queue_point(CMD_PLAIN, 2'd0, 16'h7fff, 16'hc000, 16'h8000);
      queue_point(CMD_DERIV, 2'd2, 16'h0001, 16'h0002, 16'h0003);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_config(2'd3, 2'd3, 2'd3, 2'd3);
            1: write_config(2'd1, 2'd0, 2'd0, 2'd0);
            2: write_config(2'd3, 2'd0, 2'd3, 2'd0);
            3: write_config(2'd0, 2'd3, 2'd3, 2'd3);
            default: write_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                  2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         endcase
         // one long stretch with both sides always willing
         idle_pct = (ph == 0) ? 0 : 35;
         stall_pct = (ph == 0) ? 0 : 35;
         nv_eff = (cfg_num_vars == 0) ? 1 : int'(cfg_num_vars);
         for (int n = 0; n < 18; n++) begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_DERIV : CMD_PLAIN;
            if ($urandom_range(0, 99) < 80)
               dvar = 2'($urandom_range(0, nv_eff - 1));
            else
               dvar = 2'($urandom_range(0, 3));
            queue_point(cmd, dvar, pick_coord(), pick_coord(), pick_coord());
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("tensor_monomial_basis_generator regression: pass");
      else
         $display("tensor_monomial_basis_generator regression: fail");
      $finish;
   end

endmodule

// ----- tensor_monomial_basis_generator.f -----
+incdir+rtl/core
rtl/core/tmbg_pkg.sv
rtl/core/tmbg_ram.sv
rtl/core/tmbg_power.sv
rtl/core/tmbg_seq.sv
rtl/core/tmbg_mono_pipe.sv
rtl/core/tensor_monomial_basis_generator.sv
tb/tensor_monomial_basis_generator_tb.sv
